// ----- hw/rtl/qlmt_pkg.sv -----
`timescale 1ns / 1ps

package qlmt_pkg;

  // Operation codes
  typedef logic [1:0] op_t;
  localparam op_t OP_QUERY = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  // Token handed from cell to cell, one per item in flight
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [2:0] lv;        // saturated level
    logic [3:0] x;         // column, masked to the level grid
    logic [3:0] y;         // row, masked to the level grid
    logic       bit_value;
    logic       above;     // some ancestor cell holds 0
    logic       here;      // finest level or own cell holds 0
  } tok_t;

  // Fill sweep control broadcast to every cell
  typedef struct packed {
    logic active;
    logic value;
  } sweep_t;

endpackage

// ----- hw/rtl/quadtree_level_mask_table_top.sv -----
`timescale 1ns / 1ps

// Quadtree level mask table: one bit per cell for levels 0 .. LOG2_SIDE-1.
// Input: an item is taken at a rising edge with start high and busy low
// (operation, level, cell_x, cell_y, bit_value). Every item yields exactly
// one result: out_valid is high for one cycle with handled_above and
// handled_here, taken from the table as it stood before the item.
// The item then travels down a row of LOG2_SIDE cells, one per level, one
// cell per cycle; each cell owns its level's bits in a small RAM.
// Between the transfer edge and out_valid lie the token register of each
// cell in order, and then the result register.
// The block takes a new item only once the last one has left the cell row;
// busy is high while an item is in the row.
// A clear item additionally starts a fill sweep writing zeros, in every cell
// at once, through every address of the largest cell's RAM; busy stays
// high through it.
// Reset (synchronous, rst_n low) starts the same sweep writing ones; the
// block stays busy after rst_n rises until that sweep has ended.
// The receiver cannot stall: each result is on the ports for one cycle only.
module quadtree_level_mask_table_top #(
  parameter int unsigned LOG2_SIDE = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [2:0] in_level,
  input  logic [3:0] in_cell_x,
  input  logic [3:0] in_cell_y,
  input  logic       in_bit_value,
  output logic       out_valid,
  output logic       out_handled_above,
  output logic       out_handled_here
);
  import qlmt_pkg::*;

  localparam int unsigned SW   = (LOG2_SIDE > 1) ? 2 * (LOG2_SIDE - 1) : 1;
  localparam logic [2:0]  LMAX = 3'(LOG2_SIDE);

  tok_t          chain [LOG2_SIDE+1];
  logic          accept;
  logic          row_busy;
  logic [LOG2_SIDE-1:0] row_valid;
  logic [2:0]    lv_sat;
  logic [3:0]    cmask;

  sweep_t        sweep_r;
  sweep_t        sweep_nxt;
  logic [SW-1:0] sweep_cnt_r;
  logic [SW-1:0] sweep_cnt_nxt;

  logic          out_valid_r;
  logic          above_r;
  logic          here_r;

  // Handshake
  assign accept = start && !busy;
  assign busy   = row_busy || sweep_r.active;

  // Level saturates to the finest; coordinates masked to the level grid
  assign lv_sat = (in_level > LMAX) ? LMAX : in_level;
  assign cmask  = ~(4'hF << lv_sat);

  always_comb begin
    chain[0].valid     = accept;
    chain[0].op        = in_operation;
    chain[0].lv        = lv_sat;
    chain[0].x         = in_cell_x & cmask;
    chain[0].y         = in_cell_y & cmask;
    chain[0].bit_value = in_bit_value;
    chain[0].above     = 1'b0;
    chain[0].here      = 1'b1;
  end

  // Cell row, one per level
  for (genvar k = 0; k < LOG2_SIDE; k++) begin : g_cell
    qlmt_cell #(
      .LEVEL     (k),
      .SW        (SW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .tok_i        (chain[k]),
      .sweep_i      (sweep_r),
      .sweep_addr_i (sweep_cnt_r),
      .tok_o        (chain[k+1])
    );
    assign row_valid[k] = chain[k+1].valid;
  end

  assign row_busy = |row_valid;

  // Fill sweep: ones after reset, zeros after a clear item leaves the row
  always_comb begin
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    if (sweep_r.active) begin
      sweep_cnt_nxt = sweep_cnt_r + 1'b1;
      if (&sweep_cnt_r) begin
        sweep_nxt.active = 1'b0;
      end
    end else if (chain[LOG2_SIDE].valid && (chain[LOG2_SIDE].op == OP_CLEAR)) begin
      sweep_nxt.active = 1'b1;
      sweep_nxt.value  = 1'b0;
      sweep_cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r.active <= 1'b1;
      sweep_r.value  <= 1'b1;
      sweep_cnt_r    <= '0;
    end else begin
      sweep_r        <= sweep_nxt;
      sweep_cnt_r    <= sweep_cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[LOG2_SIDE].valid;
    end
    above_r <= chain[LOG2_SIDE].above;
    here_r  <= chain[LOG2_SIDE].here;
  end

  assign out_valid         = out_valid_r;
  assign out_handled_above = above_r;
  assign out_handled_here  = here_r;

  // Checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(row_valid))
    else $error("more than one item in the cell row");

  a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r.active |-> !row_busy)
    else $error("fill sweep overlaps an item in the cell row");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low right after a transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

// ----- hw/rtl/qlmt_ram.sv -----
`timescale 1ns / 1ps

module qlmt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/qlmt_cell.sv -----
`timescale 1ns / 1ps

module qlmt_cell #(
  parameter int unsigned LEVEL     = 0,
  parameter int unsigned SW        = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qlmt_pkg::tok_t    tok_i,
  input  qlmt_pkg::sweep_t  sweep_i,
  input  logic [SW-1:0]     sweep_addr_i,
  output qlmt_pkg::tok_t    tok_o
);
  import qlmt_pkg::*;

  // Level 0 has one bit; it gets a two-entry RAM to keep a 1-bit address
  localparam int unsigned DEPTH = (LEVEL == 0) ? 2 : (4 ** LEVEL);
  localparam int unsigned AW    = (LEVEL == 0) ? 1 : 2 * LEVEL;
  localparam logic [2:0]  LV3   = 3'(LEVEL);

  tok_t          tok_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] addr_r;
  logic          rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;

  // Cell address at this level: coordinates shifted down from the item level
  if (LEVEL == 0) begin : g_root
    assign rd_addr = '0;
  end else begin : g_addr
    localparam int unsigned XW = LEVEL + 4;
    logic [2:0]    sh;
    logic [XW-1:0] xs;
    logic [XW-1:0] ys;
    assign sh      = tok_i.lv - LV3;
    assign xs      = {{LEVEL{1'b0}}, tok_i.x} >> sh;
    assign ys      = {{LEVEL{1'b0}}, tok_i.y} >> sh;
    assign rd_addr = {ys[LEVEL-1:0], xs[LEVEL-1:0]};
  end

  // Token stage; the read data lines up with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
    addr_r <= rd_addr;
  end

  // Fold this level's bit into the flags
  always_comb begin
    tok_o = tok_r;
    if (tok_r.valid) begin
      if ((LV3 < tok_r.lv) && !rdata) begin
        tok_o.above = 1'b1;
      end
      if (LV3 == tok_r.lv) begin
        tok_o.here = ~rdata;
      end
    end
  end

  // Write port: fill sweep, or a write item at this level after its read
  always_comb begin
    if (sweep_i.active) begin
      we    = 1'b1;
      waddr = sweep_addr_i[AW-1:0];
      wdata = sweep_i.value;
    end else begin
      we    = tok_r.valid && (tok_r.op == OP_WRITE) && (tok_r.lv == LV3);
      waddr = addr_r;
      wdata = tok_r.bit_value;
    end
  end

  qlmt_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

endmodule

// ----- tb/sv/quadtree_level_mask_table_top_test.sv -----
`timescale 1ns / 1ps

module quadtree_level_mask_table_top_test;
  import qlmt_pkg::*;

  localparam int unsigned LOG2_SIDE  = 4;
  localparam int unsigned CELL_COUNT = ((1 << (2 * LOG2_SIDE)) - 1) / 3;
  localparam int unsigned RAND_ITEMS = 400;
  // opcode left unused by the block: state must stay untouched
  localparam op_t OP_SPARE = 2'd3;

  typedef struct {
    op_t         op;
    logic [2:0]  lv;
    logic [3:0]  x;
    logic [3:0]  y;
    logic        bv;
    int unsigned gap_pct;   // chance the sender idles before this item
    bit          drain;     // hold until every pending result has come
  } cell_cmd_t;

  typedef struct {
    logic above;
    logic here;
  } cell_flags_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_operation = OP_QUERY;
  logic [2:0] in_level = 3'd0;
  logic [3:0] in_cell_x = 4'd0;
  logic [3:0] in_cell_y = 4'd0;
  logic       in_bit_value = 1'b0;
  logic       out_valid;
  logic       out_handled_above;
  logic       out_handled_here;

  cell_cmd_t   cmd_q[$];
  cell_flags_t flags_due_q[$];
  logic        cell_map[CELL_COUNT];
  int unsigned cmds_total = 0;
  int unsigned cmds_fired = 0;
  int unsigned fill_gap_pct = 27;
  bit          fill_drain = 1'b0;
  bit          failed = 1'b0;

  quadtree_level_mask_table_top #(.LOG2_SIDE(LOG2_SIDE)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_level         (in_level),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .in_bit_value     (in_bit_value),
    .out_valid        (out_valid),
    .out_handled_above(out_handled_above),
    .out_handled_here (out_handled_here)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // first bit of level k in the packed table
  function automatic int unsigned level_base(int unsigned k);
    return ((1 << (2 * k)) - 1) / 3;
  endfunction

  // flags from the table as it stands, then apply the operation
  task automatic predict_flags(input op_t op, input logic [2:0] lv_in, input logic [3:0] x_in,
                               input logic [3:0] y_in, input logic bv);
    int unsigned lv, xm, ym, sh, k;
    cell_flags_t f;
    lv = (lv_in > LOG2_SIDE) ? LOG2_SIDE : lv_in;
    xm = x_in & ((1 << lv) - 1);
    ym = y_in & ((1 << lv) - 1);
    f.above = 1'b0;
    for (k = 0; k < lv; k++) begin
      sh = lv - k;
      if (!cell_map[level_base(k) + ((ym >> sh) << k) + (xm >> sh)]) f.above = 1'b1;
    end
    f.here = (lv == LOG2_SIDE) ? 1'b1 : !cell_map[level_base(lv) + (ym << lv) + xm];
    flags_due_q = {flags_due_q, f};
    if (op == OP_WRITE && lv < LOG2_SIDE) begin
      cell_map[level_base(lv) + (ym << lv) + xm] = bv;
    end else if (op == OP_CLEAR) begin
      foreach (cell_map[i]) cell_map[i] = 1'b0;
    end
  endtask

  task automatic push_cmd(input op_t op, input logic [2:0] lv, input logic [3:0] x,
                          input logic [3:0] y, input logic bv);
    cell_cmd_t c;
    c.op = op;
    c.lv = lv;
    c.x = x;
    c.y = y;
    c.bv = bv;
    c.gap_pct = fill_gap_pct;
    c.drain = fill_drain;
    fill_drain = 1'b0;
    cmd_q = {cmd_q, c};
    cmds_total++;
  endtask

  // Open a path of ones from the root to one cell, write a random bit there,
  // then query down to the finest level; sometimes one ancestor write is dropped.
  task automatic queue_path();
    logic [3:0] fx, fy;
    int unsigned d, k, skip;
    fx = 4'($urandom);
    fy = 4'($urandom);
    d = $urandom_range(LOG2_SIDE - 1);
    skip = ($urandom_range(99) < 20) ? $urandom_range(LOG2_SIDE) : LOG2_SIDE + 1;
    for (k = 0; k < d; k++) begin
      if (k != skip) push_cmd(OP_WRITE, 3'(k), fx >> (LOG2_SIDE - k), fy >> (LOG2_SIDE - k), 1'b1);
    end
    push_cmd(OP_WRITE, 3'(d), fx >> (LOG2_SIDE - d), fy >> (LOG2_SIDE - d), 1'($urandom));
    for (k = d; k <= LOG2_SIDE; k++) begin
      push_cmd(OP_QUERY, 3'(k), fx >> (LOG2_SIDE - k), fy >> (LOG2_SIDE - k), 1'($urandom));
    end
  endtask

  task automatic queue_noise();
    int unsigned r;
    op_t op;
    logic [2:0] lv;
    r = $urandom_range(99);
    if (r < 40) op = OP_QUERY;
    else if (r < 88) op = OP_WRITE;
    else if (r < 91) op = OP_CLEAR;
    else op = OP_SPARE;
    lv = ($urandom_range(99) < 75) ? 3'($urandom_range(LOG2_SIDE)) : 3'($urandom);
    if ($urandom_range(39) == 0) fill_drain = 1'b1;
    push_cmd(op, lv, 4'($urandom), 4'($urandom), 1'($urandom));
  endtask

  // Driver: transfer at an edge with start high and busy low
  always @(posedge clk) begin : drive_cmds
    cell_cmd_t nxt;
    logic fire;
    fire = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (fire) begin
        predict_flags(in_operation, in_level, in_cell_x, in_cell_y, in_bit_value);
        cmds_fired++;
      end
      if (!start || fire) begin
        if (cmd_q.size() != 0 && !(cmd_q[0].drain && flags_due_q.size() != 0) &&
            $urandom_range(99) >= cmd_q[0].gap_pct) begin
          nxt = cmd_q.pop_front();
          start <= 1'b1;
          in_operation <= nxt.op;
          in_level <= nxt.lv;
          in_cell_x <= nxt.x;
          in_cell_y <= nxt.y;
          in_bit_value <= nxt.bv;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest pending flags
  always @(posedge clk) begin : check_flags
    cell_flags_t f;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (flags_due_q.size() == 0) begin
        $display("%0t: result with nothing pending: above=%b here=%b", $time,
                 out_handled_above, out_handled_here);
        failed = 1'b1;
      end else begin
        f = flags_due_q.pop_front();
        if (out_handled_above !== f.above) begin
          $display("%0t: handled_above expected %b got %b", $time, f.above, out_handled_above);
          failed = 1'b1;
        end
        if (out_handled_here !== f.here) begin
          $display("%0t: handled_here expected %b got %b", $time, f.here, out_handled_here);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("quadtree_level_mask_table_top_test failed");
    $finish;
  end

  initial begin
    foreach (cell_map[i]) cell_map[i] = 1'b1;

    // directed: reset state, finest and saturated levels, masking,
    // ignored writes, spare opcode, clear and rebuild
    push_cmd(OP_QUERY, 3'd0, 4'd0, 4'd0, 1'b0);
    push_cmd(OP_QUERY, 3'd4, 4'd15, 4'd15, 1'b1);
    push_cmd(OP_QUERY, 3'd7, 4'd15, 4'd15, 1'b1);
    push_cmd(OP_WRITE, 3'd0, 4'd0, 4'd0, 1'b0);
    push_cmd(OP_QUERY, 3'd1, 4'd1, 4'd1, 1'b0);
    push_cmd(OP_QUERY, 3'd7, 4'd9, 4'd6, 1'b0);
    push_cmd(OP_WRITE, 3'd0, 4'd15, 4'd15, 1'b1);
    push_cmd(OP_WRITE, 3'd3, 4'd7, 4'd7, 1'b0);
    push_cmd(OP_QUERY, 3'd3, 4'd7, 4'd7, 1'b0);
    push_cmd(OP_QUERY, 3'd4, 4'd15, 4'd15, 1'b0);
    push_cmd(OP_QUERY, 3'd2, 4'd3, 4'd3, 1'b0);
    push_cmd(OP_WRITE, 3'd4, 4'd5, 4'd9, 1'b0);
    push_cmd(OP_WRITE, 3'd6, 4'd5, 4'd9, 1'b0);
    push_cmd(OP_QUERY, 3'd4, 4'd5, 4'd9, 1'b0);
    push_cmd(OP_SPARE, 3'd2, 4'd15, 4'd15, 1'b0);
    push_cmd(OP_WRITE, 3'd2, 4'd15, 4'd12, 1'b0);
    push_cmd(OP_QUERY, 3'd2, 4'd3, 4'd0, 1'b0);
    push_cmd(OP_QUERY, 3'd3, 4'd6, 4'd1, 1'b0);
    fill_drain = 1'b1;
    push_cmd(OP_CLEAR, 3'd1, 4'd1, 4'd0, 1'b1);
    push_cmd(OP_QUERY, 3'd0, 4'd0, 4'd0, 1'b0);
    push_cmd(OP_QUERY, 3'd3, 4'd5, 4'd2, 1'b0);
    push_cmd(OP_WRITE, 3'd0, 4'd0, 4'd0, 1'b1);
    push_cmd(OP_WRITE, 3'd1, 4'd1, 4'd1, 1'b1);
    push_cmd(OP_QUERY, 3'd2, 4'd2, 4'd3, 1'b0);
    push_cmd(OP_QUERY, 3'd4, 4'd0, 4'd0, 1'b0);

    // random: mostly path sequences, the rest noise; three idling phases
    while (cmds_total < RAND_ITEMS + 25) begin
      if (cmds_total >= 25 + 2 * RAND_ITEMS / 3 && fill_gap_pct != 0) begin
        fill_gap_pct = 0;
        fill_drain = 1'b1;
      end else if (cmds_total >= 25 + RAND_ITEMS / 3 && fill_gap_pct == 27) begin
        fill_gap_pct = 69;
        fill_drain = 1'b1;
      end
      if ($urandom_range(99) < 55) queue_path();
      else queue_noise();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmds_fired != cmds_total || flags_due_q.size() != 0) @(posedge clk);
    repeat (LOG2_SIDE + 4) @(posedge clk);
    if (!failed) begin
      $display("quadtree_level_mask_table_top_test passed");
    end else begin
      $display("quadtree_level_mask_table_top_test failed");
    end
    $finish;
  end

endmodule
